// ===== src/random_field_ising_metropolis_defines.svh =====
// ----------------------------------------------------------------------------
// Random-field Ising Metropolis engine: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RANDOM_FIELD_ISING_METROPOLIS_DEFINES_SVH
`define RANDOM_FIELD_ISING_METROPOLIS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFIM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfim assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfim assertion failed");

`endif

// ===== src/rfim_pkg.sv =====
// ----------------------------------------------------------------------------
// Random-field Ising Metropolis engine: shared definitions
// Field widths, operation codes and the acceptance probability table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfim_pkg;

	localparam int SIDE_DEFAULT = 128;

	localparam int FUNC_W   = 2;
	localparam int COORD_W  = 7;
	localparam int FIELD_W  = 16;
	localparam int DRAW_W   = 16;
	localparam int BETA_W   = 16;
	localparam int DE_W     = 18;
	localparam int FRAC_W   = 12;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	// Inverse temperature at reset, about 1/2.269 in unsigned Q4.12.
	localparam logic [BETA_W-1:0] BETA_RESET = 16'd1805;

	// Neighbor sum offset: four down spins give -4.0 in Q.12.
	localparam logic signed [DE_W-1:0] NSUM_OFFSET = 18'sd16384;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_READ   = 2'd2
	} func_t;

	// exp(-x) table in steps of 1/64, indexed by (dE * beta) >> 18.
	localparam int EXP_ENTRIES = 1024;
	localparam int EXP_IDX_W   = 10;
	localparam int EXP_SHIFT   = 18;
	localparam int PROB_W      = 16;
	localparam longint unsigned EXP_RATIO = 64'd4228380000;

	typedef logic [PROB_W-1:0] exp_rom_t [EXP_ENTRIES];

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		longint unsigned v;
		longint unsigned e;
		v = 64'd1 << 32;
		for (int i = 0; i < EXP_ENTRIES; i++) begin
			e = (v + 64'd32768) >> 16;
			rom[i] = (e > 64'd65535) ? 16'hFFFF : e[PROB_W-1:0];
			v = (v * EXP_RATIO + (64'd1 << 31)) >> 32;
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== src/rfim_ram.sv =====
// ----------------------------------------------------------------------------
// Random-field Ising Metropolis engine: generic RAM
// One write port and one read port; read data is registered, and a read of
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfim_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/random_field_ising_metropolis.sv =====
// Results pass the stage-one, stage-two and output registers. No new item is
// taken while one is in stage one, due to the read-modify-write of the spin
// memories (stage two writes back while the next item's reads issue).
// Reset clears the pipeline and output valid flags and loads beta = 1805;
// the site memories are not cleared, so sites must be written before use.
// ----------------------------------------------------------------------------
// Random-field Ising Metropolis engine: top level
// Stores spins and local fields of a periodic lattice in on-chip RAM and
// performs write, read and Metropolis update operations on single sites.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "random_field_ising_metropolis_defines.svh"

module random_field_ising_metropolis #(
	parameter int SIDE = rfim_pkg::SIDE_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rfim_pkg::BETA_W-1:0]     cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// row [6:0], col [13:7], spin_in [14], field_in [30:15],
	// uniform_draw [46:31], zero [47]
	input  logic [rfim_pkg::IN_DATA_W-1:0]  s_tdata,
	// func [1:0]
	input  logic [rfim_pkg::FUNC_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// spin_out [0], flipped [1], energy_change [19:2], zero [23:20]
	output logic [rfim_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W  = $clog2(SIDE);
	localparam int DEPTH  = SIDE * SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NPORTS = 5;
	localparam int COORD_VALUES = 2 ** rfim_pkg::COORD_W;
	localparam int PROD_W = rfim_pkg::DE_W - 1 + rfim_pkg::BETA_W;
	localparam int DE_W = rfim_pkg::DE_W;
	localparam int FIELD_W = rfim_pkg::FIELD_W;

	// Read port roles: center, up, down, left, right.
	localparam int P_C = 0;
	localparam int P_U = 1;
	localparam int P_D = 2;
	localparam int P_L = 3;
	localparam int P_R = 4;

	function automatic logic [ADDR_W-1:0] site_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(SIDE) + ADDR_W'(c);
	endfunction

	logic [rfim_pkg::BETA_W-1:0] beta_q;

	logic                         accept;
	rfim_pkg::func_t              in_func;
	logic [rfim_pkg::COORD_W-1:0] in_row;
	logic [rfim_pkg::COORD_W-1:0] in_col;
	logic                         in_spin;
	logic [FIELD_W-1:0]           in_field;
	logic [rfim_pkg::DRAW_W-1:0]  in_draw;

	logic [IDX_W-1:0] mod_tbl [COORD_VALUES];
	logic [IDX_W-1:0] r, c, rp, rn, cp, cn;
	logic [ADDR_W-1:0] rd_addr [NPORTS];
	logic              rd_spin [NPORTS];
	logic [FIELD_W-1:0] rd_field;

	// Stage 1: memory data arrives, energy change and product are formed.
	logic                        s1_valid;
	logic                        fwd_s1;
	rfim_pkg::func_t             func_s1;
	logic [ADDR_W-1:0]           addr_s1 [NPORTS];
	logic                        spin_in_s1;
	logic [FIELD_W-1:0]          field_in_s1;
	logic [rfim_pkg::DRAW_W-1:0] draw_s1;

	logic                       spin_fw [NPORTS];
	logic [FIELD_W-1:0]         field_fw;
	logic [2:0]                 ups;
	logic signed [DE_W-1:0]     nsum_x;
	logic signed [DE_W-1:0]     local_sum;
	logic signed [DE_W-1:0]     local_x2;
	logic signed [DE_W-1:0]     de_s1;
	logic [PROD_W-1:0]          prod_s1;

	// Stage 2: decision, write-back and result.
	logic                        s2_valid;
	logic                        s2_go;
	rfim_pkg::func_t             func_s2;
	logic [ADDR_W-1:0]           addr_s2;
	logic                        spin_c_s2;
	logic                        spin_in_s2;
	logic [FIELD_W-1:0]          field_s2;
	logic signed [DE_W-1:0]      de_s2;
	logic                        exp_over_s2;
	logic [rfim_pkg::PROB_W-1:0] exp_val_s2;
	logic [rfim_pkg::DRAW_W-1:0] draw_s2;

	logic [rfim_pkg::EXP_IDX_W-1:0] exp_idx;
	logic [rfim_pkg::PROB_W-1:0]    prob;
	logic                           take;
	logic                           new_spin;
	logic                           flip;
	logic [DE_W-1:0]                de_out;
	logic                           wr_req;
	logic                           wr_en;

	logic                wr_spin_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [FIELD_W-1:0]  wr_field_q;

	logic                           out_valid_q;
	logic [rfim_pkg::OUT_DATA_W-1:0] out_data_q;

	// ------------------------------------------------------------------
	// Input unpacking and address generation
	// ------------------------------------------------------------------
	assign in_func  = rfim_pkg::func_t'(s_tuser);
	assign in_row   = s_tdata[6:0];
	assign in_col   = s_tdata[13:7];
	assign in_spin  = s_tdata[14];
	assign in_field = s_tdata[30:15];
	assign in_draw  = s_tdata[46:31];

	for (genvar i = 0; i < COORD_VALUES; i++) begin : g_mod
		assign mod_tbl[i] = IDX_W'(i % SIDE);
	end

	always_comb begin
		r  = mod_tbl[in_row];
		c  = mod_tbl[in_col];
		rp = (r == '0) ? IDX_W'(SIDE - 1) : r - 1'b1;
		rn = (r == IDX_W'(SIDE - 1)) ? '0 : r + 1'b1;
		cp = (c == '0) ? IDX_W'(SIDE - 1) : c - 1'b1;
		cn = (c == IDX_W'(SIDE - 1)) ? '0 : c + 1'b1;
		rd_addr[P_C] = site_addr(r, c);
		rd_addr[P_U] = site_addr(rp, c);
		rd_addr[P_D] = site_addr(rn, c);
		rd_addr[P_L] = site_addr(r, cp);
		rd_addr[P_R] = site_addr(r, cn);
	end

	// ------------------------------------------------------------------
	// Site memories: five identical spin copies, one per read port
	// ------------------------------------------------------------------
	for (genvar p = 0; p < NPORTS; p++) begin : g_spin
		rfim_ram #(
			.WIDTH(1),
			.DEPTH(DEPTH)
		) u_spin_ram (
			.clk  (clk),
			.we   (wr_en),
			.waddr(addr_s2),
			.wdata(new_spin),
			.raddr(rd_addr[p]),
			.rdata(rd_spin[p])
		);
	end

	rfim_ram #(
		.WIDTH(FIELD_W),
		.DEPTH(DEPTH)
	) u_field_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s2),
		.wdata(field_s2),
		.raddr(rd_addr[P_C]),
		.rdata(rd_field)
	);

	// ------------------------------------------------------------------
	// Handshake and pipeline control
	// ------------------------------------------------------------------
	assign s2_go    = s2_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid && (!s2_valid || s2_go);
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = s2_go && wr_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q      <= rfim_pkg::BETA_RESET;
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				beta_q <= cfg_wdata;
			end
			s1_valid <= accept;
			s2_valid <= s1_valid || (s2_valid && !s2_go);
			if (accept) begin
				fwd_s1 <= wr_en;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= in_func;
			addr_s1     <= rd_addr;
			spin_in_s1  <= in_spin;
			field_in_s1 <= in_field;
			draw_s1     <= in_draw;
		end
	end

	// The write retired at the same edge as this item's reads is not yet
	// visible in the memory data, so it is forwarded here.
	always_comb begin
		for (int p = 0; p < NPORTS; p++) begin
			spin_fw[p] = (fwd_s1 && addr_s1[p] == wr_addr_q) ? wr_spin_q : rd_spin[p];
		end
		field_fw = (fwd_s1 && addr_s1[P_C] == wr_addr_q) ? wr_field_q : rd_field;
		ups = {2'b00, spin_fw[P_U]} + {2'b00, spin_fw[P_D]} +
			{2'b00, spin_fw[P_L]} + {2'b00, spin_fw[P_R]};
		nsum_x = $signed({{(DE_W - 3 - rfim_pkg::FRAC_W - 1){1'b0}}, ups,
			{(rfim_pkg::FRAC_W + 1){1'b0}}}) - rfim_pkg::NSUM_OFFSET;
		local_sum = nsum_x + $signed({{(DE_W - FIELD_W){field_fw[FIELD_W-1]}}, field_fw});
		local_x2 = {local_sum[DE_W-2:0], 1'b0};
		de_s1 = spin_fw[P_C] ? local_x2 : -local_x2;
		prod_s1 = PROD_W'(de_s1[DE_W-2:0]) * PROD_W'(beta_q);
		exp_idx = prod_s1[rfim_pkg::EXP_SHIFT +: rfim_pkg::EXP_IDX_W];
	end

	// ------------------------------------------------------------------
	// Stage 2
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s1_valid) begin
			func_s2     <= func_s1;
			addr_s2     <= addr_s1[P_C];
			spin_c_s2   <= spin_fw[P_C];
			spin_in_s2  <= spin_in_s1;
			field_s2    <= (func_s1 == rfim_pkg::FUNC_WRITE) ? field_in_s1 : field_fw;
			de_s2       <= de_s1;
			exp_over_s2 <= (prod_s1[PROD_W-1:rfim_pkg::EXP_SHIFT + rfim_pkg::EXP_IDX_W] != '0);
			exp_val_s2  <= rfim_pkg::EXP_ROM[exp_idx];
			draw_s2     <= draw_s1;
		end
	end

	always_comb begin
		prob = exp_over_s2 ? '0 : exp_val_s2;
		take = de_s2[DE_W-1] || (draw_s2 < prob);

		unique case (func_s2)
			rfim_pkg::FUNC_WRITE: begin
				new_spin = spin_in_s2;
				flip     = 1'b0;
				de_out   = '0;
				wr_req   = 1'b1;
			end
			rfim_pkg::FUNC_UPDATE: begin
				new_spin = spin_c_s2 ^ take;
				flip     = take;
				de_out   = de_s2;
				wr_req   = 1'b1;
			end
			default: begin
				new_spin = spin_c_s2;
				flip     = 1'b0;
				de_out   = '0;
				wr_req   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_q  <= addr_s2;
			wr_spin_q  <= new_spin;
			wr_field_q <= field_s2;
		end
		if (s2_go) begin
			out_data_q <= {{(rfim_pkg::OUT_DATA_W - DE_W - 2){1'b0}}, de_out, flip, new_spin};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`RFIM_ASSERT_NEXT(a_accept_enters_s1, clk, arst_n, accept, s1_valid && !s_tready)
	`RFIM_ASSERT_NEXT(a_s1_always_advances, clk, arst_n, s1_valid, s2_valid)
	`RFIM_ASSERT_NEXT(a_s2_holds_when_blocked, clk, arst_n, s2_valid && !s2_go, s2_valid && $stable(addr_s2) && $stable(de_s2))

endmodule

// ===== verif/ising_update_checker.sv =====
// ----------------------------------------------------------------------------
// Random-field Ising Metropolis engine: transfer checker
// Watches the configuration port and both stream channels. It keeps its own
// copy of the lattice, the inverse temperature and the acceptance table, works
// out the result of every input transfer, and compares each output transfer
// field by field with the oldest result still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ising_update_checker #(
	parameter int SIDE = rfim_pkg::SIDE_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rfim_pkg::BETA_W-1:0]     cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rfim_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [rfim_pkg::FUNC_W-1:0]     s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rfim_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              outstanding,
	output int                              mismatches
);

	localparam longint unsigned DECAY_PER_STEP = 64'd4228380000;

	typedef struct packed {
		logic                             spin;
		logic                             flipped;
		logic signed [rfim_pkg::DE_W-1:0] energy;
	} site_result_t;

	logic                                spin_mem [SIDE*SIDE];
	logic signed [rfim_pkg::FIELD_W-1:0] field_mem [SIDE*SIDE];
	logic [rfim_pkg::PROB_W-1:0]         boltzmann_lut [rfim_pkg::EXP_ENTRIES];
	logic [rfim_pkg::BETA_W-1:0]         beta;
	site_result_t                        awaited_results [$];
	int                                  err_count = 0;

	// Entry i holds exp(-i/64) in Q0.16, built by repeated fixed-point decay.
	initial begin : lut_build
		longint unsigned level;
		longint unsigned rounded;
		level = 64'd1 << 32;
		for (int i = 0; i < rfim_pkg::EXP_ENTRIES; i++) begin
			rounded = (level + 64'd32768) >> 16;
			boltzmann_lut[i] = (rounded > 64'd65535) ? '1 : rounded[rfim_pkg::PROB_W-1:0];
			level = (level * DECAY_PER_STEP + (64'd1 << 31)) >> 32;
		end
	end

	function automatic int spin_sign(int site);
		return spin_mem[site] ? 1 : -1;
	endfunction

	function automatic site_result_t apply_op(logic [rfim_pkg::FUNC_W-1:0] func,
			logic [rfim_pkg::COORD_W-1:0] row, logic [rfim_pkg::COORD_W-1:0] col,
			logic spin_in, logic [rfim_pkg::FIELD_W-1:0] field_in,
			logic [rfim_pkg::DRAW_W-1:0] draw);
		site_result_t res;
		int r, c, site, nsum, s;
		longint de;
		longint unsigned weighted, lut_idx;
		logic [rfim_pkg::PROB_W-1:0] prob;
		logic take;
		r = row % SIDE;
		c = col % SIDE;
		site = r * SIDE + c;
		res = '0;
		res.spin = spin_mem[site];
		case (func)
			rfim_pkg::FUNC_WRITE: begin
				spin_mem[site] = spin_in;
				field_mem[site] = field_in;
				res.spin = spin_in;
			end
			rfim_pkg::FUNC_UPDATE: begin
				nsum = spin_sign(((r + SIDE - 1) % SIDE) * SIDE + c)
					+ spin_sign(((r + 1) % SIDE) * SIDE + c)
					+ spin_sign(r * SIDE + (c + SIDE - 1) % SIDE)
					+ spin_sign(r * SIDE + (c + 1) % SIDE);
				s = res.spin ? 1 : -1;
				de = longint'(2 * s) * (longint'(nsum) * 4096 + longint'(field_mem[site]));
				if (de < 0) begin
					take = 1'b1;
				end else begin
					weighted = $unsigned(de) * beta;
					lut_idx = weighted >> rfim_pkg::EXP_SHIFT;
					prob = (lut_idx < rfim_pkg::EXP_ENTRIES) ? boltzmann_lut[lut_idx] : '0;
					take = draw < prob;
				end
				res.energy = de[rfim_pkg::DE_W-1:0];
				if (take) begin
					spin_mem[site] = ~res.spin;
					res.spin = ~res.spin;
					res.flipped = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		site_result_t got;
		site_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			beta <= rfim_pkg::BETA_RESET;
			outstanding <= 0;
			mismatches <= err_count;
		end else begin
			if (cfg_we) begin
				beta <= cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				got.spin = m_tdata[0];
				got.flipped = m_tdata[1];
				got.energy = m_tdata[19:2];
				if (awaited_results.size() == 0) begin
					$error("result transfer with none awaited: tdata %h", m_tdata);
					err_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got.spin !== want.spin) begin
						$error("spin_out mismatch: expected %0d, actual %0d", want.spin, got.spin);
						err_count++;
					end
					if (got.flipped !== want.flipped) begin
						$error("flipped mismatch: expected %0d, actual %0d",
							want.flipped, got.flipped);
						err_count++;
					end
					if (got.energy !== want.energy) begin
						$error("energy_change mismatch: expected %0d, actual %0d",
							want.energy, got.energy);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(apply_op(s_tuser, s_tdata[6:0], s_tdata[13:7],
					s_tdata[14], s_tdata[30:15], s_tdata[46:31]));
			end
			outstanding <= awaited_results.size();
			mismatches <= err_count;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Random-field Ising Metropolis engine: testbench top
// Drives directed corner cases around the lattice wrap and then phases of
// random write, read and update sequences under several inverse temperatures
// and idle patterns. Sites are always written before they or their neighbors
// are used. The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int SIDE            = rfim_pkg::SIDE_DEFAULT;
	localparam int NUM_PHASES      = 5;
	localparam int ITEMS_PER_PHASE = 280;
	localparam logic [rfim_pkg::FUNC_W-1:0] FUNC_READ_ALIAS = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [rfim_pkg::BETA_W-1:0]     cfg_wdata = '0;
	logic                            s_tvalid = 1'b0;
	logic [rfim_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [rfim_pkg::FUNC_W-1:0]     s_tuser = '0;
	logic                            m_tready = 1'b0;
	logic                            s_tready;
	logic                            m_tvalid;
	logic [rfim_pkg::OUT_DATA_W-1:0] m_tdata;

	int outstanding;
	int mismatches;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int phase_items = 0;
	bit site_written [SIDE*SIDE];

	always #6 clk = ~clk;

	random_field_ising_metropolis #(.SIDE(SIDE)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ising_update_checker #(.SIDE(SIDE)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic send_op(input logic [rfim_pkg::FUNC_W-1:0] func, input int row,
			input int col, input logic spin, input logic [rfim_pkg::FIELD_W-1:0] field,
			input logic [rfim_pkg::DRAW_W-1:0] draw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {1'b0, draw, field, spin, 7'(col), 7'(row)};
		if (func == rfim_pkg::FUNC_WRITE) begin
			site_written[row * SIDE + col] = 1'b1;
		end
		phase_items++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_beta(input logic [rfim_pkg::BETA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Most picks land in the band around the wrap so neighborhoods fill up fast.
	function automatic int pick_coord();
		if ($urandom_range(99) < 70) begin
			return (SIDE - 3 + $urandom_range(5)) % SIDE;
		end
		return $urandom_range(SIDE - 1);
	endfunction

	function automatic logic [rfim_pkg::FIELD_W-1:0] rand_field();
		if ($urandom_range(1)) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(16383)) - 16'd8192;
	endfunction

	function automatic logic [rfim_pkg::DRAW_W-1:0] rand_draw();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic ensure_written(input int row, input int col);
		if (!site_written[row * SIDE + col]) begin
			send_op(rfim_pkg::FUNC_WRITE, row, col, 1'($urandom_range(1)), rand_field(),
				rand_draw());
		end
	endtask

	task automatic random_sequence();
		int row, col, pick;
		row = pick_coord();
		col = pick_coord();
		pick = $urandom_range(99);
		if (pick < 60) begin
			ensure_written(row, col);
			ensure_written((row + SIDE - 1) % SIDE, col);
			ensure_written((row + 1) % SIDE, col);
			ensure_written(row, (col + SIDE - 1) % SIDE);
			ensure_written(row, (col + 1) % SIDE);
			send_op(rfim_pkg::FUNC_UPDATE, row, col, 1'($urandom_range(1)), rand_field(),
				rand_draw());
		end else if (pick < 75) begin
			send_op(rfim_pkg::FUNC_WRITE, row, col, 1'($urandom_range(1)), rand_field(),
				rand_draw());
		end else begin
			ensure_written(row, col);
			send_op((pick < 90) ? rfim_pkg::FUNC_READ : FUNC_READ_ALIAS, row, col,
				1'($urandom_range(1)), rand_field(), rand_draw());
		end
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner of the lattice with wrapped neighbors, field extremes and a
		// neighborhood that sums to zero, so the first update sees zero energy.
		send_op(rfim_pkg::FUNC_WRITE, SIDE - 1, 0, 1'b1, 16'h7FFF, '0);
		send_op(rfim_pkg::FUNC_WRITE, 1, 0, 1'b1, 16'h8000, '0);
		send_op(rfim_pkg::FUNC_WRITE, 0, SIDE - 1, 1'b0, '0, '0);
		send_op(rfim_pkg::FUNC_WRITE, 0, 1, 1'b0, '0, '0);
		send_op(rfim_pkg::FUNC_WRITE, 0, 0, 1'b1, '0, '0);
		send_op(rfim_pkg::FUNC_UPDATE, 0, 0, 1'b0, '0, 16'hFFFF);
		send_op(rfim_pkg::FUNC_UPDATE, 0, 0, 1'b0, '0, 16'hFFFE);
		send_op(rfim_pkg::FUNC_UPDATE, 0, 0, 1'b0, '0, 16'h0000);
		send_op(rfim_pkg::FUNC_WRITE, 0, 0, 1'b1, 16'h7FFF, '0);
		send_op(rfim_pkg::FUNC_UPDATE, 0, 0, 1'b0, '0, 16'h0000);
		send_op(rfim_pkg::FUNC_UPDATE, 0, 0, 1'b0, '0, 16'hFFFF);
		send_op(rfim_pkg::FUNC_WRITE, 0, 0, 1'b0, 16'h8000, '0);
		send_op(rfim_pkg::FUNC_UPDATE, 0, 0, 1'b0, '0, 16'hFFFF);
		send_op(rfim_pkg::FUNC_READ, 0, 0, 1'b0, '0, '0);
		send_op(FUNC_READ_ALIAS, 1, 0, 1'b0, '0, '0);
		send_op(rfim_pkg::FUNC_WRITE, SIDE - 1, SIDE - 1, 1'b1, 16'hFFFF, 16'hFFFF);
		send_op(rfim_pkg::FUNC_READ, SIDE - 1, SIDE - 1, 1'b1, 16'hFFFF, 16'hFFFF);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 45;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 45;
				end
				default: begin
					src_idle_pct = 10;
					sink_stall_pct = 10;
				end
			endcase
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1: write_beta('0);
					2: write_beta('1);
					3: write_beta(16'($urandom));
					default: write_beta(16'($urandom_range(4000, 600)));
				endcase
			end
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) random_sequence();
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
